>>> hdl/cusc_pkg.sv
// cusc_pkg: types, codes and constants of the chunked update session controller
// no dependencies; used by the stream interface and the top level
package cusc_pkg;

    // request codes
    typedef enum logic [2:0] {
        REQ_ENTER    = 3'd0,
        REQ_PAYLOAD  = 3'd1,
        REQ_COMMIT   = 3'd2,
        REQ_FINALIZE = 3'd3,
        REQ_APPLY    = 3'd4,
        REQ_ABORT    = 3'd5,
        REQ_TICK     = 3'd6
    } req_code_t;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_RECEIVING = 2'd1,
        PH_VERIFIED  = 2'd2,
        PH_FAILED    = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_SIZE       = 4'd1,
        ERR_CHUNKS     = 4'd2,
        ERR_CRC32      = 4'd3,
        ERR_TIMEOUT    = 4'd4,
        ERR_FLASH      = 4'd5,
        ERR_UNVERIFIED = 4'd6,
        ERR_LATCH_BUSY = 4'd7,
        ERR_INCOMPLETE = 4'd8
    } err_code_t;

    // configuration register indexes
    typedef enum logic [3:0] {
        CFG_MAX_IMAGE_BYTES = 4'd0,
        CFG_TIMEOUT_MS      = 4'd1
    } cfg_index_t;

    localparam logic [16:0] MAX_IMAGE_RESET = 17'd65536;
    localparam logic [31:0] TIMEOUT_RESET   = 32'd10000;
    localparam logic [31:0] MIN_IMAGE_BYTES = 32'd8;

    localparam logic [15:0] CRC16_INIT = 16'hFFFF;
    localparam logic [15:0] CRC16_POLY = 16'h1021;

    // received map is kept in rows of 2**ROW_BITS_LOG bits
    localparam int ROW_BITS_LOG = 5;
    localparam int ROW_W        = 1 << ROW_BITS_LOG;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] now_ms;
        logic [31:0] image_size;
        logic [31:0] image_crc32;
        logic [15:0] total_chunks;
        logic        latch_idle;
        logic [15:0] chunk_index;
        logic [15:0] chunk_len;
        logic [15:0] chunk_crc16;
        logic [7:0]  data_byte;
        logic        flash_ok;
        logic [31:0] staged_crc32;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  session_state;
        logic [3:0]  error_code;
        logic [9:0]  chunks_received;
        logic        chunk_accepted;
        logic [15:0] write_offset;
        logic        erase_request;
        logic        reboot_request;
    } rsp_item_t;

    typedef struct packed {
        logic [3:0]  reg_index;
        logic [31:0] wdata;
    } cfg_item_t;

    // crc16-ccitt, msb first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC16_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/cusc_stream_if.sv
// cusc_stream_if: valid/ready channel carrying one payload item of type T
// depends on cusc_pkg for the default payload type
interface cusc_stream_if #(
    parameter type T = cusc_pkg::req_item_t
);
    import cusc_pkg::*;

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> hdl/chunked_update_session_controller_top.sv
// chunked_update_session_controller_top: firmware update session controller
// pipeline: an accepted request item waits in the request register, its result in the result register
// throughput: one item per cycle while rsp.ready is high; the request register and the result register
//   are the only stages, the received-chunk row is read at acceptance
// reset: rst_n clears state and config at once; the chunk map rows carry valid
//   flops, so no clearing pass is needed
// depends on cusc_pkg and cusc_stream_if
module chunked_update_session_controller_top #(
    parameter int CHUNK_BYTES = 128,
    parameter int MAX_CHUNKS  = 512
) (
    input  logic          clk,
    input  logic          rst_n,
    cusc_stream_if.sink   req,
    cusc_stream_if.source rsp,
    cusc_stream_if.sink   cfg
);
    import cusc_pkg::*;

    localparam int IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int MAP_W  = (IDX_W > ROW_BITS_LOG) ? IDX_W : ROW_BITS_LOG + 1;
    localparam int ROW_AW = MAP_W - ROW_BITS_LOG;
    localparam int ROWS   = 1 << ROW_AW;
    localparam int EXP_W  = $clog2(MAX_CHUNKS + 1);
    localparam int CMP_W  = (EXP_W > 10) ? EXP_W : 10;

    // configuration
    logic [16:0] max_image_reg;
    logic [31:0] timeout_reg;

    // session state
    phase_t      phase_reg, phase_next;
    err_code_t   err_reg, err_next;
    logic [16:0] stored_size_reg, stored_size_next;
    logic [31:0] stored_crc_reg, stored_crc_next;
    logic [EXP_W-1:0] expected_reg, expected_next;
    logic [9:0]  count_reg, count_next;
    logic [31:0] last_act_reg, last_act_next;
    logic [15:0] payload_crc_reg, payload_crc_next;
    logic [ROWS-1:0] row_valid_reg;
    logic [ROW_W-1:0] map_mem [ROWS];

    // request stage
    logic             s1_valid_reg;
    req_item_t        s1_item_reg;
    logic [15:0]      s1_off_reg;
    logic             s1_cnt_ok_reg;
    logic [ROW_W-1:0] s1_row_reg;

    // result stage
    logic      out_valid_reg;
    rsp_item_t out_data_reg, out_data_next;

    logic in_fire, s1_fire;

    assign s1_fire   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_fire;
    assign in_fire   = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;
    assign cfg.ready = 1'b1;

    // work done at acceptance: constant multiplies and the chunk count check
    logic [31:0]       in_idx_prod;
    logic [32:0]       in_cnt_prod, in_cnt_lo, in_size;
    logic              in_cnt_ok;
    logic [ROW_AW-1:0] in_raddr;

    always_comb
    begin
        in_idx_prod = 32'(req.data.chunk_index) * 32'(CHUNK_BYTES);
        in_cnt_prod = 33'(req.data.total_chunks) * 33'(CHUNK_BYTES);
        in_cnt_lo   = in_cnt_prod - 33'(CHUNK_BYTES);
        in_size     = 33'(req.data.image_size);
        // count is nonzero, at most MAX_CHUNKS, and equals size divided by chunk size rounded up
        in_cnt_ok   = (req.data.total_chunks != 16'd0)
                   && (17'(req.data.total_chunks) <= 17'(MAX_CHUNKS))
                   && (in_cnt_prod >= in_size) && (in_cnt_lo < in_size);
        in_raddr    = req.data.chunk_index[MAP_W-1:ROW_BITS_LOG];
    end

    // chunk map access for the item in the request stage
    logic [15:0]             s1_idx;
    logic [ROW_AW-1:0]       s1_ra;
    logic [ROW_BITS_LOG-1:0] s1_bit;
    logic [ROW_W-1:0]        row_cur, row_wdata;
    logic [15:0]             want_len;
    logic                    in_range, dup;

    always_comb
    begin
        s1_idx    = s1_item_reg.chunk_index;
        s1_ra     = s1_idx[MAP_W-1:ROW_BITS_LOG];
        s1_bit    = s1_idx[ROW_BITS_LOG-1:0];
        row_cur   = row_valid_reg[s1_ra] ? s1_row_reg : '0;
        row_wdata = row_cur | (ROW_W'(1) << s1_bit);
        dup       = row_cur[s1_bit];
        in_range  = (17'(s1_idx) < 17'(expected_reg)) && (17'(s1_idx) < 17'(MAX_CHUNKS));
        // last chunk holds the remainder of the image
        if ((17'(s1_idx) + 17'd1) == 17'(expected_reg))
        begin
            want_len = stored_size_reg[15:0] - s1_off_reg;
        end
        else
        begin
            want_len = 16'(CHUNK_BYTES);
        end
    end

    logic sess_clear, map_we;

    always_comb
    begin
        phase_next       = phase_reg;
        err_next         = err_reg;
        stored_size_next = stored_size_reg;
        stored_crc_next  = stored_crc_reg;
        expected_next    = expected_reg;
        count_next       = count_reg;
        last_act_next    = last_act_reg;
        payload_crc_next = payload_crc_reg;
        sess_clear       = 1'b0;
        map_we           = 1'b0;
        out_data_next    = '0;

        case (s1_item_reg.req_type)
            REQ_ENTER:
            begin
                if (!s1_item_reg.latch_idle)
                begin
                    phase_next = PH_FAILED;
                    err_next   = ERR_LATCH_BUSY;
                end
                else if (s1_item_reg.image_size < MIN_IMAGE_BYTES
                      || s1_item_reg.image_size > 32'(max_image_reg))
                begin
                    phase_next = PH_FAILED;
                    err_next   = ERR_SIZE;
                end
                else if (!s1_cnt_ok_reg)
                begin
                    phase_next = PH_FAILED;
                    err_next   = ERR_CHUNKS;
                end
                else
                begin
                    sess_clear       = 1'b1;
                    stored_size_next = s1_item_reg.image_size[16:0];
                    stored_crc_next  = s1_item_reg.image_crc32;
                    expected_next    = EXP_W'(s1_item_reg.total_chunks);
                    last_act_next    = s1_item_reg.now_ms;
                    phase_next       = PH_RECEIVING;
                    err_next         = ERR_NONE;
                    out_data_next.erase_request = 1'b1;
                end
            end
            REQ_PAYLOAD:
            begin
                payload_crc_next = crc16_byte(payload_crc_reg, s1_item_reg.data_byte);
            end
            REQ_COMMIT:
            begin
                payload_crc_next = CRC16_INIT;
                if (phase_reg == PH_RECEIVING)
                begin
                    last_act_next = s1_item_reg.now_ms;
                    // bad index, length, duplicate or crc mismatch is dropped
                    if (in_range && s1_item_reg.chunk_len == want_len && !dup
                        && payload_crc_reg == s1_item_reg.chunk_crc16)
                    begin
                        if (!s1_item_reg.flash_ok)
                        begin
                            phase_next = PH_FAILED;
                            err_next   = ERR_FLASH;
                        end
                        else
                        begin
                            map_we     = 1'b1;
                            count_next = count_reg + 10'd1;
                            out_data_next.chunk_accepted = 1'b1;
                            out_data_next.write_offset   = s1_off_reg;
                        end
                    end
                end
            end
            REQ_FINALIZE:
            begin
                if (phase_reg == PH_RECEIVING)
                begin
                    last_act_next = s1_item_reg.now_ms;
                    if (CMP_W'(count_reg) != CMP_W'(expected_reg))
                    begin
                        err_next = ERR_INCOMPLETE;
                    end
                    else if (s1_item_reg.staged_crc32 == stored_crc_reg)
                    begin
                        phase_next = PH_VERIFIED;
                        err_next   = ERR_NONE;
                    end
                    else
                    begin
                        phase_next = PH_FAILED;
                        err_next   = ERR_CRC32;
                    end
                end
            end
            REQ_APPLY:
            begin
                if (phase_reg != PH_VERIFIED)
                begin
                    err_next = ERR_UNVERIFIED;
                end
                else if (!s1_item_reg.flash_ok)
                begin
                    phase_next = PH_FAILED;
                    err_next   = ERR_FLASH;
                end
                else
                begin
                    out_data_next.reboot_request = 1'b1;
                end
            end
            REQ_ABORT:
            begin
                sess_clear       = 1'b1;
                stored_size_next = '0;
                stored_crc_next  = '0;
                expected_next    = '0;
                phase_next       = PH_IDLE;
                err_next         = ERR_NONE;
            end
            REQ_TICK:
            begin
                if (phase_reg == PH_RECEIVING
                    && (s1_item_reg.now_ms - last_act_reg) > timeout_reg)
                begin
                    sess_clear       = 1'b1;
                    stored_size_next = '0;
                    stored_crc_next  = '0;
                    expected_next    = '0;
                    phase_next       = PH_FAILED;
                    err_next         = ERR_TIMEOUT;
                end
            end
            default:
            begin
            end
        endcase

        if (sess_clear)
        begin
            count_next       = '0;
            payload_crc_next = CRC16_INIT;
        end

        out_data_next.session_state   = phase_next;
        out_data_next.error_code      = err_next;
        out_data_next.chunks_received = count_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_image_reg <= MAX_IMAGE_RESET;
            timeout_reg   <= TIMEOUT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.data.reg_index)
                CFG_MAX_IMAGE_BYTES: max_image_reg <= cfg.data.wdata[16:0];
                CFG_TIMEOUT_MS:      timeout_reg   <= cfg.data.wdata;
                default:
                begin
                end
            endcase
        end
    end

    // control and session state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_IDLE;
            err_reg         <= ERR_NONE;
            stored_size_reg <= '0;
            stored_crc_reg  <= '0;
            expected_reg    <= '0;
            count_reg       <= '0;
            last_act_reg    <= '0;
            payload_crc_reg <= CRC16_INIT;
            row_valid_reg   <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                phase_reg       <= phase_next;
                err_reg         <= err_next;
                stored_size_reg <= stored_size_next;
                stored_crc_reg  <= stored_crc_next;
                expected_reg    <= expected_next;
                count_reg       <= count_next;
                last_act_reg    <= last_act_next;
                payload_crc_reg <= payload_crc_next;
                if (sess_clear)
                begin
                    row_valid_reg <= '0;
                end
                else if (map_we)
                begin
                    row_valid_reg[s1_ra] <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg   <= req.data;
            s1_off_reg    <= in_idx_prod[15:0];
            s1_cnt_ok_reg <= in_cnt_ok;
        end
        if (s1_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // chunk map memory, row written by the item leaving the request stage
    always_ff @(posedge clk)
    begin
        if (s1_fire && map_we)
        begin
            map_mem[s1_ra] <= row_wdata;
        end
    end

    // row read at acceptance; same-row write in this cycle is forwarded
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (s1_fire && map_we && s1_ra == in_raddr)
            begin
                s1_row_reg <= row_wdata;
            end
            else
            begin
                s1_row_reg <= map_mem[in_raddr];
            end
        end
    end

endmodule
